FILE: sv/cbm_pkg.sv
// cbm_pkg: shared types and constants for the cartridge bank mapper with clock registers
// used by the channel interfaces, the access decoder and the top level
package cbm_pkg;

    // result action codes
    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_ROM_READ  = 3'd1,
        ACT_RAM_READ  = 3'd2,
        ACT_RAM_WRITE = 3'd3,
        ACT_DIRECT    = 3'd4
    } t_action;

    localparam int ROM_ADDR_W = 22;
    localparam int RAM_ADDR_W = 21;
    localparam int ROM_OFF_W  = 14;   // 16 KiB rom bank
    localparam int RAM_OFF_W  = 13;   // 8 KiB ram bank
    localparam int CLK_REGS   = 5;

    // bus map boundaries
    localparam logic [15:0] ADDR_ROM_BANK_SEL = 16'h2000;
    localparam logic [15:0] ADDR_ROM_BANKED   = 16'h4000;
    localparam logic [15:0] ADDR_LATCH        = 16'h6000;
    localparam logic [15:0] ADDR_UNMAPPED     = 16'h8000;
    localparam logic [15:0] ADDR_WIN_LO       = 16'hA000;
    localparam logic [15:0] ADDR_WIN_HI       = 16'hBFFF;

    localparam logic [3:0] ENABLE_KEY   = 4'hA;
    localparam logic [7:0] SEL_RAM_MAX  = 8'h03;
    localparam logic [7:0] SEL_CLK_LO   = 8'h08;
    localparam logic [7:0] SEL_CLK_HI   = 8'h0C;
    localparam logic [7:0] LATCH_VALUE  = 8'h01;
    localparam logic [7:0] ROM_BANK_RST = 8'h01;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_IDX_RAM_PRESENT = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [15:0] address;
        logic [7:0]  write_value;
        logic [5:0]  time_seconds;
        logic [5:0]  time_minutes;
        logic [4:0]  time_hours;
    } t_item;

    typedef struct packed {
        t_action                 action;
        logic [ROM_ADDR_W-1:0]   rom_address;
        logic [RAM_ADDR_W-1:0]   ram_address;
        logic [7:0]              read_data;
        logic [7:0]              ram_write_data;
    } t_result;

    typedef struct packed {
        logic                        ram_clock_enable;
        logic [7:0]                  rom_bank;
        logic [7:0]                  bank_select;
        logic                        ram_mode;
        logic [CLK_REGS-1:0][7:0]    clock_bytes;
    } t_state;

endpackage

FILE: sv/cbm_if.sv
// cbm_in_if / cbm_out_if: valid/ready channels for bus accesses and mapper results
// depends on cbm_pkg
interface cbm_in_if;
    import cbm_pkg::*;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [15:0] address;
    logic [7:0]  write_value;
    logic [5:0]  time_seconds;
    logic [5:0]  time_minutes;
    logic [4:0]  time_hours;

    modport source (output valid, kind, address, write_value, time_seconds,
                    time_minutes, time_hours, input ready);
    modport sink   (input valid, kind, address, write_value, time_seconds,
                    time_minutes, time_hours, output ready);
endinterface

interface cbm_out_if;
    import cbm_pkg::*;
    logic                  valid;
    logic                  ready;
    t_action               action;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [RAM_ADDR_W-1:0] ram_address;
    logic [7:0]            read_data;
    logic [7:0]            ram_write_data;

    modport source (output valid, action, rom_address, ram_address, read_data,
                    ram_write_data, input ready);
    modport sink   (input valid, action, rom_address, ram_address, read_data,
                    ram_write_data, output ready);
endinterface

FILE: sv/cbm_decode.sv
// cbm_decode: decodes one bus access against the mapper state
// gives the result and the next mapper state; depends on cbm_pkg
module cbm_decode (
    input  logic            i_ram_present,
    input  cbm_pkg::t_item  i_item,
    input  cbm_pkg::t_state i_state,
    output cbm_pkg::t_result o_result,
    output cbm_pkg::t_state  o_state
);
    import cbm_pkg::*;

    logic                 w_in_window;
    logic                 w_window_open;
    logic                 w_clk_sel_ok;
    logic [2:0]           w_clk_idx;
    logic [RAM_ADDR_W-1:0] w_ram_off;
    logic [7:0]           w_val;
    logic [15:0]          w_addr;

    assign w_addr        = i_item.address;
    assign w_val         = i_item.write_value;
    assign w_in_window   = (w_addr >= ADDR_WIN_LO) && (w_addr <= ADDR_WIN_HI);
    assign w_window_open = i_ram_present && i_state.ram_clock_enable;
    assign w_clk_sel_ok  = (i_state.bank_select >= SEL_CLK_LO) &&
                           (i_state.bank_select <= SEL_CLK_HI);
    assign w_clk_idx     = 3'(i_state.bank_select - SEL_CLK_LO);
    // bank times 8 KiB plus window offset
    assign w_ram_off     = {i_state.bank_select, w_addr[RAM_OFF_W-1:0]};

    always_comb begin
        o_result = '0;
        o_result.action = ACT_NONE;
        o_state  = i_state;
        if (!i_item.kind) begin
            if (w_addr < ADDR_ROM_BANKED) begin
                o_result.action      = ACT_ROM_READ;
                o_result.rom_address = {6'b0, w_addr};
            end else if (w_addr < ADDR_UNMAPPED) begin
                o_result.action      = ACT_ROM_READ;
                o_result.rom_address = {i_state.rom_bank, w_addr[ROM_OFF_W-1:0]};
            end else if (w_in_window && w_window_open) begin
                if (i_state.ram_mode) begin
                    o_result.action      = ACT_RAM_READ;
                    o_result.ram_address = w_ram_off;
                end else if (w_clk_sel_ok) begin
                    o_result.action    = ACT_DIRECT;
                    o_result.read_data = i_state.clock_bytes[w_clk_idx];
                end
            end
        end else begin
            if (w_addr < ADDR_ROM_BANK_SEL) begin
                o_state.ram_clock_enable = (w_val[3:0] == ENABLE_KEY);
            end else if (w_in_window) begin
                if (w_window_open) begin
                    if (i_state.ram_mode) begin
                        o_result.action         = ACT_RAM_WRITE;
                        o_result.ram_address    = w_ram_off;
                        o_result.ram_write_data = w_val;
                    end else if (w_clk_sel_ok) begin
                        o_state.clock_bytes[w_clk_idx] = w_val;
                    end
                end
            end else if (w_addr < ADDR_ROM_BANKED) begin
                o_state.rom_bank = (w_val == 8'd0) ? ROM_BANK_RST : w_val;
            end else if (w_addr < ADDR_LATCH) begin
                if (w_val <= SEL_RAM_MAX) begin
                    o_state.ram_mode = 1'b1;
                end else if (w_val >= SEL_CLK_LO && w_val <= SEL_CLK_HI) begin
                    o_state.ram_mode = 1'b0;
                end
                o_state.bank_select = w_val;
            end else if (w_addr < ADDR_UNMAPPED) begin
                // latch copies time of day, no ready check
                if (w_val == LATCH_VALUE) begin
                    o_state.clock_bytes[0] = {2'b0, i_item.time_seconds};
                    o_state.clock_bytes[1] = {2'b0, i_item.time_minutes};
                    o_state.clock_bytes[2] = {3'b0, i_item.time_hours};
                end
            end
        end
    end

endmodule

FILE: sv/cartridge_bank_mapper_rtc_core.sv
// cartridge_bank_mapper_rtc_core: top level of the cartridge bank mapper with clock registers
// depends on cbm_pkg, cbm_in_if / cbm_out_if and cbm_decode
//
// usage:
//   i_in carries one cpu bus access per beat (kind, address, write data, host time)
//   o_out returns one result beat per access: action code, physical rom or ram
//   address, clock register data or ram write data
//   apb port holds ram_present at byte address 0 (bit 0), reset value 1
//   each beat is captured in an input register, decoded against the bank state and
//   placed in the result register, which drives o_out; one beat per cycle is
//   sustained while o_out does not stall
//   bank state updates at the same edge that loads the result register
//   when o_out stalls the result holds, one more beat is taken into the input
//   register, then i_in.ready drops until the result drains
//   reset puts rom bank 1, ram banking mode, select 0, enable off, clock bytes 0
//   and empties both registers
module cartridge_bank_mapper_rtc_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cbm_in_if.sink                           i_in,
    cbm_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [cbm_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [cbm_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [cbm_pkg::CFG_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import cbm_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;
    t_state  r_state;
    t_state  n_state;
    t_result n_out;
    logic    r_ram_present;
    logic    w_adv;
    logic    w_in_take;
    logic    w_cfg_wr;

    // stage moves when the result register is free or being drained
    assign w_adv       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_adv;
    assign w_in_take   = i_in.valid && i_in.ready;

    cbm_decode u_decode (
        .i_ram_present (r_ram_present),
        .i_item        (r_in_item),
        .i_state       (r_state),
        .o_result      (n_out),
        .o_state       (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item.kind         <= i_in.kind;
            r_in_item.address      <= i_in.address;
            r_in_item.write_value  <= i_in.write_value;
            r_in_item.time_seconds <= i_in.time_seconds;
            r_in_item.time_minutes <= i_in.time_minutes;
            r_in_item.time_hours   <= i_in.time_hours;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.ram_clock_enable <= 1'b0;
            r_state.rom_bank         <= ROM_BANK_RST;
            r_state.bank_select      <= 8'd0;
            r_state.ram_mode         <= 1'b1;
            r_state.clock_bytes      <= '0;
        end else if (w_adv) begin
            r_state <= n_state;
        end
    end

    // apb register file
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ram_present <= 1'b1;
        end else if (w_cfg_wr && (paddr[CFG_ADDR_W-1] == REG_IDX_RAM_PRESENT)) begin
            r_ram_present <= pwdata[0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[CFG_ADDR_W-1] == REG_IDX_RAM_PRESENT) begin
            prdata = {{(CFG_DATA_W-1){1'b0}}, r_ram_present};
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.action         = r_out.action;
    assign o_out.rom_address    = r_out.rom_address;
    assign o_out.ram_address    = r_out.ram_address;
    assign o_out.read_data      = r_out.read_data;
    assign o_out.ram_write_data = r_out.ram_write_data;

    // bank state only moves with a decoded beat
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_state))
        else $error("bank state changed without a beat");

    // rom bank never holds zero
    a_rom_bank_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.rom_bank != 8'd0)
        else $error("rom bank is zero");

    // clock mode is entered only by a clock select
    a_clk_mode_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_state.ram_mode) |->
            (r_state.bank_select >= SEL_CLK_LO && r_state.bank_select <= SEL_CLK_HI))
        else $error("clock mode without clock select");

    // a waiting input beat is not lost while the result stalls
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_item))
        else $error("stalled input beat lost");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for cartridge_bank_mapper_rtc_core, bus access in, mapped result out
// depends on cbm_pkg, cbm_in_if / cbm_out_if and the core; predicts each result beat in a class
module tb;
    import cbm_pkg::*;

    localparam int unsigned ROM_BANK_BYTES = 16384;
    localparam int unsigned RAM_BANK_BYTES = 8192;
    localparam logic [CFG_ADDR_W-1:0] RAM_PRESENT_ADDR = CFG_ADDR_W'(4 * REG_IDX_RAM_PRESENT);
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 4;

    typedef enum {STALL_NONE, STALL_PATTERN, STALL_RANDOM, STALL_HEAVY} t_stall_mode;

    // tracks the bank registers and clock bytes, queues the mapped result of every access
    class bank_map_model;
        bit         ram_present;
        bit         enable;
        bit [7:0]   rom_bank;
        bit [7:0]   bank_select;
        bit         ram_mode;
        bit [7:0]   clock_bytes [CLK_REGS];
        t_result    pending_results [$];
        int unsigned errors;

        function new();
            ram_present = 1'b1;
            enable      = 1'b0;
            rom_bank    = 8'd1;
            bank_select = 8'd0;
            ram_mode    = 1'b1;
            foreach (clock_bytes[i]) clock_bytes[i] = 8'd0;
            errors      = 0;
        endfunction

        function bit clock_selected();
            return bank_select >= SEL_CLK_LO && bank_select <= SEL_CLK_HI;
        endfunction

        function void note_access(t_item it);
            t_result     r;
            bit          in_window;
            bit          window_open;
            int unsigned ram_off;
            int unsigned rom_off;
            r = '0;
            r.action = ACT_NONE;
            in_window   = it.address >= ADDR_WIN_LO && it.address <= ADDR_WIN_HI;
            window_open = ram_present && enable;
            ram_off = int'(it.address) - int'(ADDR_WIN_LO) + RAM_BANK_BYTES * bank_select;
            if (!it.kind) begin
                if (it.address < ADDR_ROM_BANKED) begin
                    r.action = ACT_ROM_READ;
                    r.rom_address = ROM_ADDR_W'(it.address);
                end else if (it.address < ADDR_UNMAPPED) begin
                    rom_off = int'(it.address) - int'(ADDR_ROM_BANKED) + ROM_BANK_BYTES * rom_bank;
                    r.action = ACT_ROM_READ;
                    r.rom_address = ROM_ADDR_W'(rom_off);
                end else if (in_window && window_open) begin
                    if (ram_mode) begin
                        r.action = ACT_RAM_READ;
                        r.ram_address = RAM_ADDR_W'(ram_off);
                    end else if (clock_selected()) begin
                        r.action = ACT_DIRECT;
                        r.read_data = clock_bytes[bank_select - SEL_CLK_LO];
                    end
                end
            end else begin
                if (it.address < ADDR_ROM_BANK_SEL) begin
                    enable = (it.write_value[3:0] == ENABLE_KEY);
                end else if (in_window) begin
                    if (window_open) begin
                        if (ram_mode) begin
                            r.action = ACT_RAM_WRITE;
                            r.ram_address = RAM_ADDR_W'(ram_off);
                            r.ram_write_data = it.write_value;
                        end else if (clock_selected()) begin
                            clock_bytes[bank_select - SEL_CLK_LO] = it.write_value;
                        end
                    end
                end else if (it.address < ADDR_ROM_BANKED) begin
                    rom_bank = (it.write_value == 8'd0) ? 8'd1 : it.write_value;
                end else if (it.address < ADDR_LATCH) begin
                    if (it.write_value <= SEL_RAM_MAX)
                        ram_mode = 1'b1;
                    else if (it.write_value >= SEL_CLK_LO && it.write_value <= SEL_CLK_HI)
                        ram_mode = 1'b0;
                    bank_select = it.write_value;
                end else if (it.address < ADDR_UNMAPPED) begin
                    if (it.write_value == LATCH_VALUE) begin
                        clock_bytes[0] = 8'(it.time_seconds);
                        clock_bytes[1] = 8'(it.time_minutes);
                        clock_bytes[2] = 8'(it.time_hours);
                    end
                end
            end
            pending_results.push_back(r);
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                report($sformatf("result beat with no access pending, action %0d", got.action));
                return;
            end
            want = pending_results.pop_front();
            if (got.action !== want.action)
                report($sformatf("action %0d, want %0d", got.action, want.action));
            if (got.rom_address !== want.rom_address)
                report($sformatf("rom_address %h, want %h", got.rom_address, want.rom_address));
            if (got.ram_address !== want.ram_address)
                report($sformatf("ram_address %h, want %h", got.ram_address, want.ram_address));
            if (got.read_data !== want.read_data)
                report($sformatf("read_data %h, want %h", got.read_data, want.read_data));
            if (got.ram_write_data !== want.ram_write_data)
                report($sformatf("ram_write_data %h, want %h",
                                 got.ram_write_data, want.ram_write_data));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    cbm_in_if  in_bus ();
    cbm_out_if out_bus ();

    cartridge_bank_mapper_rtc_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bank_map_model mapper = new();

    int unsigned burst_left    = 0;
    bit          sender_steady = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // receiver stall pattern, drawn anew when each random-length run ends
    t_stall_mode stall_mode    = STALL_NONE;
    int unsigned stall_left    = 0;
    int unsigned pat_pos       = 0;
    logic [15:0] stall_pattern = 16'hFFFF;

    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode    = t_stall_mode'($urandom_range(0, 3));
            stall_left    = $urandom_range(16, 160);
            stall_pattern = 16'($urandom);
        end
        stall_left--;
        pat_pos = (pat_pos + 1) % 16;
        case (stall_mode)
            STALL_NONE:    out_bus.ready = 1'b1;
            STALL_PATTERN: out_bus.ready = stall_pattern[pat_pos];
            STALL_RANDOM:  out_bus.ready = ($urandom_range(0, 3) != 0);
            default:       out_bus.ready = ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            got.action         = out_bus.action;
            got.rom_address    = out_bus.rom_address;
            got.ram_address    = out_bus.ram_address;
            got.read_data      = out_bus.read_data;
            got.ram_write_data = out_bus.ram_write_data;
            mapper.check_result(got);
        end
    end

    function automatic t_item bus_access(bit kind, logic [15:0] addr, logic [7:0] value);
        t_item it;
        it.kind         = kind;
        it.address      = addr;
        it.write_value  = value;
        it.time_seconds = 6'($urandom_range(0, 59));
        it.time_minutes = 6'($urandom_range(0, 59));
        it.time_hours   = 5'($urandom_range(0, 23));
        return it;
    endfunction

    // mostly well-formed mapper traffic: enable, bank and latch writes around window accesses
    function automatic t_item random_access();
        int unsigned pick;
        logic [7:0]  value;
        logic [3:0]  nibble;
        pick  = $urandom_range(0, 99);
        value = 8'($urandom);
        if (pick < 15)
            return bus_access(1'b0, 16'($urandom_range(0, 16'h7FFF)), value);
        if (pick < 20) begin
            nibble = ($urandom_range(0, 3) != 0) ? ENABLE_KEY : 4'($urandom);
            return bus_access(1'b1, 16'($urandom_range(0, 16'h1FFF)), {value[7:4], nibble});
        end
        if (pick < 28) begin
            if ($urandom_range(0, 5) == 0) value = 8'd0;
            return bus_access(1'b1, 16'($urandom_range(16'h2000, 16'h3FFF)), value);
        end
        if (pick < 38) begin
            case ($urandom_range(0, 2))
                0:       value = 8'($urandom_range(0, 3));
                1:       value = 8'($urandom_range(8, 12));
                default: value = 8'($urandom);
            endcase
            return bus_access(1'b1, 16'($urandom_range(16'h4000, 16'h5FFF)), value);
        end
        if (pick < 44) begin
            if ($urandom_range(0, 3) != 0) value = LATCH_VALUE;
            return bus_access(1'b1, 16'($urandom_range(16'h6000, 16'h7FFF)), value);
        end
        if (pick < 80)
            return bus_access(1'($urandom), 16'($urandom_range(16'hA000, 16'hBFFF)), value);
        if (pick < 90)
            return bus_access(1'($urandom), 16'($urandom_range(16'h8000, 16'hFFFF)), value);
        return bus_access(1'($urandom), 16'($urandom), value);
    endfunction

    task automatic drive_access(input t_item it);
        @(negedge i_clk);
        in_bus.valid        = 1'b1;
        in_bus.kind         = it.kind;
        in_bus.address      = it.address;
        in_bus.write_value  = it.write_value;
        in_bus.time_seconds = it.time_seconds;
        in_bus.time_minutes = it.time_minutes;
        in_bus.time_hours   = it.time_hours;
        do @(posedge i_clk); while (!in_bus.ready);
        mapper.note_access(it);
    endtask

    task automatic pause_sender(input int unsigned cycles);
        @(negedge i_clk);
        in_bus.valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // sender bursts with random gaps unless the current phase runs steady
    task automatic send(input t_item it);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if (!sender_steady && $urandom_range(0, 3) != 0)
                pause_sender($urandom_range(1, 8));
        end
        burst_left--;
        drive_access(it);
    endtask

    task automatic drain_results();
        pause_sender(1);
        while (mapper.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_access(input bit wr, input logic [CFG_ADDR_W-1:0] addr,
                              input logic [CFG_DATA_W-1:0] wdata,
                              output logic [CFG_DATA_W-1:0] rdata);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = wr;
        paddr   = addr;
        pwdata  = wdata;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_ram_present(input bit present);
        logic [CFG_DATA_W-1:0] rdata;
        cfg_access(1'b1, RAM_PRESENT_ADDR, CFG_DATA_W'(present), rdata);
        mapper.ram_present = present;
        cfg_access(1'b0, RAM_PRESENT_ADDR, '0, rdata);
        if (rdata !== CFG_DATA_W'(present))
            mapper.report($sformatf("ram_present reads %h, want %0d", rdata, present));
    endtask

    initial begin
        i_rst_n             = 1'b0;
        in_bus.valid        = 1'b0;
        in_bus.kind         = 1'b0;
        in_bus.address      = '0;
        in_bus.write_value  = '0;
        in_bus.time_seconds = '0;
        in_bus.time_minutes = '0;
        in_bus.time_hours   = '0;
        out_bus.ready       = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: map edges, blocked window, ram and clock modes, latch
        send(bus_access(1'b0, 16'h0000, 8'h00));
        send(bus_access(1'b0, 16'h3FFF, 8'hFF));
        send(bus_access(1'b0, 16'h4000, 8'h00));
        send(bus_access(1'b0, 16'h7FFF, 8'h00));
        send(bus_access(1'b1, 16'h2000, 8'h00));
        send(bus_access(1'b0, 16'h5555, 8'h00));
        send(bus_access(1'b1, 16'h3FFF, 8'hFF));
        send(bus_access(1'b0, 16'h7FFF, 8'h00));
        send(bus_access(1'b0, 16'hA000, 8'h00));
        send(bus_access(1'b1, 16'h0000, 8'h1A));
        send(bus_access(1'b1, 16'h4000, 8'h03));
        send(bus_access(1'b0, 16'hBFFF, 8'h00));
        send(bus_access(1'b1, 16'hA000, 8'hFF));
        send(bus_access(1'b1, 16'h5FFF, 8'h08));
        send(bus_access(1'b1, 16'h6000, LATCH_VALUE));
        send(bus_access(1'b0, 16'hA000, 8'h00));
        send(bus_access(1'b1, 16'h4000, 8'h0C));
        send(bus_access(1'b1, 16'hA123, 8'hAB));
        send(bus_access(1'b0, 16'hB000, 8'h00));
        send(bus_access(1'b1, 16'h4000, 8'h0D));
        send(bus_access(1'b0, 16'hA000, 8'h00));
        send(bus_access(1'b1, 16'hA000, 8'h55));
        send(bus_access(1'b1, 16'h6000, 8'h02));
        send(bus_access(1'b0, 16'h8000, 8'h00));
        send(bus_access(1'b1, 16'hFFFF, 8'hFF));
        send(bus_access(1'b0, 16'hC000, 8'h00));
        send(bus_access(1'b1, 16'h1FFF, 8'h0B));

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain_results();
            set_ram_present(phase % 3 != 1);
            sender_steady = (phase % 3 == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // one full stop in the middle of the first phase so the pipe empties under load
                if (phase == 0 && n == PHASE_ITEMS / 2)
                    drain_results();
                send(random_access());
            end
        end

        drain_results();
        if (mapper.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: cartridge_bank_mapper_rtc_core.f
sv/cbm_pkg.sv
sv/cbm_if.sv
sv/cbm_decode.sv
sv/cartridge_bank_mapper_rtc_core.sv
tb/tb.sv
